// ===== design/flc_pkg.sv =====
// Package for the FIFO lease lock controller: request and response payload types
// and the fixed field widths and reset constants. No dependencies.
package flc_pkg;

	localparam int MASK_W = 3;
	localparam int LEASE_W = 8;
	localparam logic [LEASE_W-1:0] LEASE_RESET = 8'd5;

	typedef struct packed {
		logic [MASK_W-1:0] acquire_mask;
		logic [MASK_W-1:0] release_mask;
	} cmd_t;

	typedef struct packed {
		logic               grant_valid;
		logic [1:0]         grant_id;
		logic [1:0]         queue_count;
		logic [LEASE_W-1:0] lease_left;
	} rsp_t;

endpackage

// ===== design/flc_step.sv =====
// Combinational next-state and response logic for one period of the lock controller.
// Depends on flc_pkg for the payload types and field widths.
module flc_step import flc_pkg::*; #(
	parameter int NUM_REQUESTERS = 3
) (
	input  cmd_t                                      cmd,
	input  logic [LEASE_W-1:0]                        lease_periods,
	input  logic [$clog2(NUM_REQUESTERS+1)-1:0]       queue_cur [NUM_REQUESTERS],
	input  logic [$clog2(NUM_REQUESTERS+1)-1:0]       length_cur,
	input  logic [LEASE_W-1:0]                        timer_cur,
	output logic [$clog2(NUM_REQUESTERS+1)-1:0]       queue_nxt [NUM_REQUESTERS],
	output logic [$clog2(NUM_REQUESTERS+1)-1:0]       length_nxt,
	output logic [LEASE_W-1:0]                        timer_nxt,
	output rsp_t                                      rsp
);

	localparam int ID_W = $clog2(NUM_REQUESTERS + 1);

	logic [NUM_REQUESTERS-1:0] acq_ext;
	logic [NUM_REQUESTERS-1:0] rel_ext;

	assign acq_ext = NUM_REQUESTERS'(cmd.acquire_mask);
	assign rel_ext = NUM_REQUESTERS'(cmd.release_mask);

	always_comb begin
		logic [ID_W-1:0]    q [NUM_REQUESTERS];
		logic [ID_W-1:0]    len;
		logic [LEASE_W-1:0] tmr;
		logic [ID_W-1:0]    id;
		logic               dup;
		logic               gv;
		logic [ID_W-1:0]    gid;

		q = queue_cur;
		len = length_cur;
		tmr = timer_cur;
		id = '0;
		dup = 1'b0;
		gv = 1'b0;
		gid = '0;

		for (int i = 0; i < NUM_REQUESTERS; i++) begin
			id = ID_W'(i + 1);
			if (acq_ext[i]) begin
				dup = 1'b0;
				for (int k = 0; k < NUM_REQUESTERS; k++) begin
					if (ID_W'(k) < len && q[k] == id) begin
						dup = 1'b1;
					end
				end
				if (!dup && len < ID_W'(NUM_REQUESTERS)) begin
					for (int k = 0; k < NUM_REQUESTERS; k++) begin
						if (ID_W'(k) == len) begin
							q[k] = id;
						end
					end
					len = len + ID_W'(1);
				end
			end else if (rel_ext[i]) begin
				if (len != '0 && q[0] == id && tmr != '0 && tmr < lease_periods) begin
					tmr = LEASE_W'(1);
				end
			end
		end

		if (tmr == LEASE_W'(1)) begin
			tmr = '0;
			if (len != '0) begin
				for (int k = 1; k < NUM_REQUESTERS; k++) begin
					q[k-1] = q[k];
				end
				len = len - ID_W'(1);
			end
		end else if (tmr > LEASE_W'(1)) begin
			tmr = tmr - LEASE_W'(1);
		end

		if (tmr == '0 && len != '0) begin
			gv = 1'b1;
			gid = q[0];
			tmr = lease_periods;
		end

		queue_nxt = q;
		length_nxt = len;
		timer_nxt = tmr;
		rsp.grant_valid = gv;
		rsp.grant_id = gid[1:0];
		rsp.queue_count = len[1:0];
		rsp.lease_left = tmr;
	end

endmodule

// ===== design/fifo_lease_lock_controller_top.sv =====
// An accepted request is held in the input stage (cmd_s1), and its response is registered in rsp_q.
// Throughput: one request per cycle; a stalled response holds the input stage.
// Reset (arst_n low, asynchronous) empties the queue, clears the lease timer and
// loads lease_periods with 5; queue entries are not cleared and are never read unwritten.
// Depends on flc_pkg and flc_step.
module fifo_lease_lock_controller_top import flc_pkg::*; #(
	parameter int NUM_REQUESTERS = 3
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [LEASE_W-1:0] cfg_wdata,
	input  logic               cmd_valid,
	output logic               cmd_stall,
	input  cmd_t               cmd,
	output logic               rsp_valid,
	input  logic               rsp_stall,
	output rsp_t               rsp
);

	localparam int ID_W = $clog2(NUM_REQUESTERS + 1);

	cmd_t               cmd_s1;
	logic               valid_s1;
	logic [ID_W-1:0]    queue_q [NUM_REQUESTERS];
	logic [ID_W-1:0]    length_q;
	logic [LEASE_W-1:0] timer_q;
	logic [LEASE_W-1:0] lease_q;
	rsp_t               rsp_q;
	logic               rsp_valid_q;

	logic [ID_W-1:0]    queue_nxt [NUM_REQUESTERS];
	logic [ID_W-1:0]    length_nxt;
	logic [LEASE_W-1:0] timer_nxt;
	rsp_t               rsp_nxt;
	logic               advance;

	assign advance = valid_s1 && (!rsp_valid_q || !rsp_stall);
	assign cmd_stall = valid_s1 && !advance;
	assign rsp_valid = rsp_valid_q;
	assign rsp = rsp_q;

	flc_step #(
		.NUM_REQUESTERS(NUM_REQUESTERS)
	) u_step (
		.cmd          (cmd_s1),
		.lease_periods(lease_q),
		.queue_cur    (queue_q),
		.length_cur   (length_q),
		.timer_cur    (timer_q),
		.queue_nxt    (queue_nxt),
		.length_nxt   (length_nxt),
		.timer_nxt    (timer_nxt),
		.rsp          (rsp_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			length_q <= '0;
			timer_q <= '0;
			lease_q <= LEASE_RESET;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				lease_q <= cfg_wdata;
			end
			if (!cmd_stall) begin
				valid_s1 <= cmd_valid;
			end
			if (advance) begin
				length_q <= length_nxt;
				timer_q <= timer_nxt;
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_valid && !cmd_stall) begin
			cmd_s1 <= cmd;
		end
		if (advance) begin
			queue_q <= queue_nxt;
			rsp_q <= rsp_nxt;
		end
	end

endmodule

// ===== tb/sv/fifo_lease_lock_controller_top_test.sv =====
// Self-checking test of fifo_lease_lock_controller_top: directed and random requests under
// several lease settings, with random gaps and stalls, checked against an inline lock model.
// Depends on flc_pkg and the controller RTL.
`timescale 1ns / 100ps

module fifo_lease_lock_controller_top_test;
	import flc_pkg::*;

	localparam int NUM_REQ = 3;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int LONG_HOLD = 160;
	localparam int MAX_REPORTS = 100;
	localparam int PHASE_ITEMS = 215;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               cfg_we = 1'b0;
	logic [LEASE_W-1:0] cfg_wdata = '0;
	logic               cmd_valid = 1'b0;
	logic               cmd_stall;
	cmd_t               cmd = '0;
	logic               rsp_valid;
	logic               rsp_stall = 1'b0;
	rsp_t               rsp;

	fifo_lease_lock_controller_top #(.NUM_REQUESTERS(NUM_REQ)) u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd       (cmd),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	cmd_t pending_cmd[$];
	rsp_t expected_rsp[$];
	int unsigned errors = 0;

	logic [1:0]         lock_queue [NUM_REQ];
	logic [1:0]         lock_len = '0;
	logic [LEASE_W-1:0] lock_timer = '0;
	logic [LEASE_W-1:0] lock_lease = LEASE_RESET;

	int unsigned drv_cycles = 0;
	int unsigned gap_left = 0;
	int unsigned mon_cycles = 0;
	int unsigned stall_left = 0;
	int unsigned rsp_taken = 0;
	int unsigned idle_cycles = 0;
	rsp_t        want;

	initial begin
		forever #4 clk = ~clk;
	end

	task automatic report_mismatch(input string what, input int unsigned got,
			input int unsigned exp_val);
		if (errors < MAX_REPORTS)
			$display("mismatch in %s: got %0d, wanted %0d (t=%0t)", what, got, exp_val, $time);
		errors++;
	endtask

	function automatic int unsigned draw_gap();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(3, 1);
		if (r < 98)
			return $urandom_range(8, 4);
		return $urandom_range(40, 9);
	endfunction

	function automatic cmd_t draw_cmd();
		cmd_t c;
		int   i;
		c = '0;
		if ($urandom_range(99) < 30) begin
			c.acquire_mask = MASK_W'($urandom);
			c.release_mask = MASK_W'($urandom);
		end else begin
			for (i = 0; i < MASK_W; i++) begin
				c.acquire_mask[i] = ($urandom_range(7) == 0);
				c.release_mask[i] = ($urandom_range(2) == 0);
			end
		end
		return c;
	endfunction

	task automatic advance_lock(input cmd_t c, output rsp_t r);
		logic [1:0] id;
		bit         seen;
		int         i;
		int         k;
		r = '0;
		for (i = 0; i < NUM_REQ; i++) begin
			id = 2'(i + 1);
			if (c.acquire_mask[i]) begin
				seen = 1'b0;
				for (k = 0; k < lock_len; k++)
					if (lock_queue[k] == id)
						seen = 1'b1;
				if (!seen && lock_len < NUM_REQ) begin
					lock_queue[lock_len] = id;
					lock_len++;
				end
			end else if (c.release_mask[i]) begin
				if (lock_len > 0 && lock_queue[0] == id && lock_timer > 0 &&
						lock_timer < lock_lease)
					lock_timer = LEASE_W'(1);
			end
		end
		if (lock_timer == 1) begin
			lock_timer = '0;
			if (lock_len > 0) begin
				for (k = 1; k < lock_len; k++)
					lock_queue[k-1] = lock_queue[k];
				lock_len--;
			end
		end else if (lock_timer > 1) begin
			lock_timer--;
		end
		if (lock_timer == 0 && lock_len > 0) begin
			r.grant_valid = 1'b1;
			r.grant_id = lock_queue[0];
			lock_timer = lock_lease;
		end
		r.queue_count = lock_len;
		r.lease_left = lock_timer;
	endtask

	task automatic wait_idle();
		do
			@(negedge clk);
		while (pending_cmd.size() != 0 || cmd_valid || expected_rsp.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	always @(posedge clk) begin
		if (!arst_n) begin
			cmd_valid <= 1'b0;
		end else begin
			drv_cycles++;
			if (cmd_valid && !cmd_stall) begin
				advance_lock(cmd, want);
				expected_rsp.push_back(want);
			end
			if (!cmd_valid || !cmd_stall) begin
				if (gap_left > 0) begin
					gap_left--;
					cmd_valid <= 1'b0;
				end else if (pending_cmd.size() != 0) begin
					cmd <= pending_cmd.pop_front();
					cmd_valid <= 1'b1;
					gap_left = (drv_cycles[8:7] == 2'b11) ? 0 : draw_gap();
				end else begin
					cmd_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n) begin
			rsp_stall <= 1'b0;
		end else begin
			mon_cycles++;
			if (rsp_valid && !rsp_stall) begin
				rsp_taken++;
				if (expected_rsp.size() == 0) begin
					report_mismatch("unexpected response", 32'(rsp), 0);
				end else begin
					want = expected_rsp.pop_front();
					if (rsp.grant_valid !== want.grant_valid)
						report_mismatch("grant_valid", rsp.grant_valid, want.grant_valid);
					if (rsp.grant_id !== want.grant_id)
						report_mismatch("grant_id", rsp.grant_id, want.grant_id);
					if (rsp.queue_count !== want.queue_count)
						report_mismatch("queue_count", rsp.queue_count, want.queue_count);
					if (rsp.lease_left !== want.lease_left)
						report_mismatch("lease_left", rsp.lease_left, want.lease_left);
				end
				if (rsp_taken % 600 == 150)
					stall_left = LONG_HOLD;
			end
			if (stall_left > 0) begin
				stall_left--;
				rsp_stall <= 1'b1;
			end else begin
				rsp_stall <= 1'b0;
				stall_left = (mon_cycles[9:8] == 2'b01) ? 0 : draw_gap();
			end
		end
	end

	always @(posedge clk) begin
		if ((cmd_valid && !cmd_stall) || (rsp_valid && !rsp_stall)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		logic [5:0]         directed [25];
		logic [LEASE_W-1:0] phase_lease [7];
		int                 j;
		int                 p;

		// Octal pairs: acquire mask, then release mask.
		directed = '{6'o00, 6'o10, 6'o10, 6'o61, 6'o77, 6'o04, 6'o07, 6'o07, 6'o07,
			6'o07, 6'o07, 6'o07, 6'o07, 6'o00, 6'o07, 6'o70, 6'o00, 6'o00, 6'o02,
			6'o00, 6'o07, 6'o00, 6'o25, 6'o52, 6'o00};
		phase_lease = '{8'd255, 8'd1, 8'd0, 8'd2, 8'd0, 8'd128, 8'd5};
		phase_lease[4] = LEASE_W'($urandom_range(254, 3));

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		for (j = 0; j < 25; j++)
			pending_cmd.push_back(cmd_t'(directed[j]));
		for (j = 0; j < PHASE_ITEMS; j++)
			pending_cmd.push_back(draw_cmd());

		for (p = 0; p < 7; p++) begin
			wait_idle();
			cfg_we <= 1'b1;
			cfg_wdata <= phase_lease[p];
			@(posedge clk);
			cfg_we <= 1'b0;
			lock_lease = phase_lease[p];
			for (j = 0; j < PHASE_ITEMS; j++)
				pending_cmd.push_back(draw_cmd());
		end

		wait_idle();
		if (errors == 0 && expected_rsp.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
